### rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  // Decoder modes.
  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_STR     = 4'd1,
    M_ESC     = 4'd2,
    M_HEX1    = 4'd3,
    M_WANT_BS = 4'd4,
    M_WANT_U  = 4'd5,
    M_HEX2    = 4'd6,
    M_CONT    = 4'd7
  } mode_e;

  // Result kinds, carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NO_QUOTE     = 3'd0,
    ERR_UNTERMINATED = 3'd1,
    ERR_BAD_ESCAPE   = 3'd2,
    ERR_BAD_UNICODE  = 3'd3,
    ERR_BAD_UTF8     = 3'd4,
    ERR_CONTROL      = 3'd5
  } err_e;

  // One result of the decoder.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       code;
  } res_t;

  localparam int unsigned MaxResults = 4;

  // All results caused by one input byte; entry 0 goes out first.
  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [2:0]            count;
  } group_t;

  // Decoder state.
  typedef struct packed {
    mode_e       mode;
    logic [20:0] acc;
    logic [9:0]  high_half;
    logic [1:0]  digit_count;
    logic [1:0]  bytes_left;
    logic [2:0]  seq_length;
  } state_t;

  localparam state_t StateReset = '{M_IDLE, 21'd0, 10'd0, 2'd0, 2'd0, 3'd0};

  // Characters that the decoder recognizes.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;

  // Control bytes produced by the short escapes.
  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlFormFeed  = 8'h0C;
  localparam logic [7:0] CtlNewline   = 8'h0A;
  localparam logic [7:0] CtlReturn    = 8'h0D;
  localparam logic [7:0] CtlTab       = 8'h09;

  function automatic res_t data_res(logic [7:0] d);
    res_t r;
    r.kind = KIND_DATA;
    r.data = d;
    r.code = ERR_NO_QUOTE;
    return r;
  endfunction

  // A group holding one result only.
  function automatic group_t single(res_t r);
    group_t g;
    g = '0;
    g.res[0] = r;
    g.count = 3'd1;
    return g;
  endfunction

  function automatic group_t error_group(err_e code);
    res_t r;
    r.kind = KIND_ERROR;
    r.data = 8'h00;
    r.code = code;
    return single(r);
  endfunction

  // Hex digit value; bit 4 is set when the character is a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return v;
  endfunction

  // UTF-8 encoding of a code point in the given number of bytes.
  function automatic group_t utf8_encode(logic [20:0] cp, logic [2:0] len);
    group_t g;
    g = '0;
    case (len)
      3'd0, 3'd1: begin
        g.res[0] = data_res({1'b0, cp[6:0]});
        g.count  = 3'd1;
      end
      3'd2: begin
        g.res[0] = data_res({3'b110, cp[10:6]});
        g.res[1] = data_res({2'b10, cp[5:0]});
        g.count  = 3'd2;
      end
      3'd3: begin
        g.res[0] = data_res({4'b1110, cp[15:12]});
        g.res[1] = data_res({2'b10, cp[11:6]});
        g.res[2] = data_res({2'b10, cp[5:0]});
        g.count  = 3'd3;
      end
      default: begin
        g.res[0] = data_res({5'b11110, cp[20:18]});
        g.res[1] = data_res({2'b10, cp[17:12]});
        g.res[2] = data_res({2'b10, cp[11:6]});
        g.res[3] = data_res({2'b10, cp[5:0]});
        g.count  = 3'd4;
      end
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### rtl/json_string_unescape_utf8_check.sv
// Channel  Direction  tdata (low bit up)               tuser      tlast
// s_axis   in         [7:0] in_byte                    at_end     -
// m_axis   out        [7:0] out_byte, [10:8] error_code kind       last
//
// A byte is first held in an input register, then decoded into the result
// register. A byte giving no result loads nothing there; a byte giving n
// results (up to four, for a 4-byte UTF-8 form) holds the input side until
// all n have gone out through the single output port. Reset clears the
// valid flags and the decoder state at once; stalls on the output hold the
// result and back up into the input.
`default_nettype none

module json_string_unescape_utf8_check
  import jsu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tuser,   // [0] at_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] error_code
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       s_fire;
  logic       advance;
  logic       emit_free;
  group_t     grp;
  res_t       res;

  assign advance       = in_valid_q && emit_free;
  assign s_axis_tready = !in_valid_q || emit_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_fire || (in_valid_q && !advance);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tuser;
    end
  end

  jsu_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .end_i   (in_end_q),
    .group_o (grp)
  );

  jsu_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && (grp.count != 3'd0)),
    .group_i (grp),
    .free_o  (emit_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, res.code, res.data};
  assign m_axis_tuser = res.kind;

endmodule

`default_nettype wire

### rtl/jsu_decode.sv
`default_nettype none

// Decoder state register and the single-pass step logic for one byte.
module jsu_decode
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       end_i,
  output group_t          group_o
);

  state_t      st_q, st_d;
  logic [4:0]  hex;
  logic [20:0] acc_hex;
  logic [15:0] cp16;
  logic [20:0] acc_cont;
  logic [1:0]  left_dec;
  logic [20:0] pair_cp;
  logic [2:0]  bmp_len;
  logic        cont_bad;
  logic [7:0]  b;

  assign b = byte_i;

  // Values shared by the hex digit and continuation paths.
  always_comb begin
    hex      = hex_value(b);
    acc_hex  = {st_q.acc[16:0], hex[3:0]};
    cp16     = acc_hex[15:0];
    acc_cont = {st_q.acc[14:0], b[5:0]};
    left_dec = st_q.bytes_left - 2'd1;
    pair_cp  = {1'b0, st_q.high_half, cp16[9:0]} + 21'h10000;
    if (cp16 < 16'h0080) begin
      bmp_len = 3'd1;
    end else if (cp16 < 16'h0800) begin
      bmp_len = 3'd2;
    end else begin
      bmp_len = 3'd3;
    end
    if (st_q.seq_length == 3'd2) begin
      cont_bad = acc_cont < 21'h80;
    end else if (st_q.seq_length == 3'd3) begin
      cont_bad = (acc_cont < 21'h800) || (acc_cont >= 21'hD800 && acc_cont <= 21'hDFFF);
    end else begin
      cont_bad = (acc_cont < 21'h10000) || (acc_cont > 21'h10FFFF);
    end
  end

  // Next state and results for the byte or end marker.
  always_comb begin
    st_d    = st_q;
    group_o = '0;
    unique case (st_q.mode)
      M_STR: begin
        if (end_i) begin
          st_d    = StateReset;
          group_o = error_group(ERR_UNTERMINATED);
        end else if (b == ChQuote) begin
          st_d    = StateReset;
          group_o = single('{KIND_DONE, 8'h00, ERR_NO_QUOTE});
        end else if (b == ChBackslash) begin
          st_d.mode = M_ESC;
        end else if (b < 8'h20) begin
          st_d    = StateReset;
          group_o = error_group(ERR_CONTROL);
        end else if (b < 8'h80) begin
          group_o = single(data_res(b));
        end else if (b[7:5] == 3'b110) begin
          st_d.acc        = {16'd0, b[4:0]};
          st_d.bytes_left = 2'd1;
          st_d.seq_length = 3'd2;
          st_d.mode       = M_CONT;
        end else if (b[7:4] == 4'b1110) begin
          st_d.acc        = {17'd0, b[3:0]};
          st_d.bytes_left = 2'd2;
          st_d.seq_length = 3'd3;
          st_d.mode       = M_CONT;
        end else if (b[7:3] == 5'b11110) begin
          st_d.acc        = {18'd0, b[2:0]};
          st_d.bytes_left = 2'd3;
          st_d.seq_length = 3'd4;
          st_d.mode       = M_CONT;
        end else begin
          st_d    = StateReset;
          group_o = error_group(ERR_BAD_UTF8);
        end
      end

      M_ESC: begin
        if (end_i) begin
          st_d    = StateReset;
          group_o = error_group(ERR_BAD_ESCAPE);
        end else begin
          st_d.mode = M_STR;
          case (b)
            ChQuote:     group_o = single(data_res(ChQuote));
            ChBackslash: group_o = single(data_res(ChBackslash));
            ChSlash:     group_o = single(data_res(ChSlash));
            ChLowerB:    group_o = single(data_res(CtlBackspace));
            ChLowerF:    group_o = single(data_res(CtlFormFeed));
            ChLowerN:    group_o = single(data_res(CtlNewline));
            ChLowerR:    group_o = single(data_res(CtlReturn));
            ChLowerT:    group_o = single(data_res(CtlTab));
            ChLowerU: begin
              st_d.mode        = M_HEX1;
              st_d.acc         = '0;
              st_d.digit_count = 2'd0;
            end
            default: begin
              st_d    = StateReset;
              group_o = error_group(ERR_BAD_ESCAPE);
            end
          endcase
        end
      end

      M_HEX1, M_HEX2: begin
        if (end_i || !hex[4]) begin
          st_d    = StateReset;
          group_o = error_group(ERR_BAD_UNICODE);
        end else if (st_q.digit_count != 2'd3) begin
          st_d.acc         = acc_hex;
          st_d.digit_count = st_q.digit_count + 2'd1;
        end else begin
          st_d.acc         = '0;
          st_d.digit_count = 2'd0;
          if (st_q.mode == M_HEX1) begin
            if (cp16 < 16'hD800 || cp16 > 16'hDFFF) begin
              st_d.mode = M_STR;
              group_o   = utf8_encode({5'd0, cp16}, bmp_len);
            end else if (cp16 >= 16'hDC00) begin
              st_d    = StateReset;
              group_o = error_group(ERR_BAD_UNICODE);
            end else begin
              // High half of a pair: a low half escape must follow.
              st_d.high_half = cp16[9:0];
              st_d.mode      = M_WANT_BS;
            end
          end else if (cp16 < 16'hDC00 || cp16 > 16'hDFFF) begin
            st_d    = StateReset;
            group_o = error_group(ERR_BAD_UNICODE);
          end else begin
            st_d.high_half = '0;
            st_d.mode      = M_STR;
            group_o        = utf8_encode(pair_cp, 3'd4);
          end
        end
      end

      M_WANT_BS: begin
        if (end_i || b != ChBackslash) begin
          st_d    = StateReset;
          group_o = error_group(ERR_BAD_UNICODE);
        end else begin
          st_d.mode = M_WANT_U;
        end
      end

      M_WANT_U: begin
        if (end_i || b != ChLowerU) begin
          st_d    = StateReset;
          group_o = error_group(ERR_BAD_UNICODE);
        end else begin
          st_d.mode        = M_HEX2;
          st_d.acc         = '0;
          st_d.digit_count = 2'd0;
        end
      end

      M_CONT: begin
        if (end_i || b[7:6] != 2'b10) begin
          st_d    = StateReset;
          group_o = error_group(ERR_BAD_UTF8);
        end else begin
          st_d.acc        = acc_cont;
          st_d.bytes_left = left_dec;
          if (left_dec == 2'd0) begin
            if (cont_bad) begin
              st_d    = StateReset;
              group_o = error_group(ERR_BAD_UTF8);
            end else begin
              st_d.acc        = '0;
              st_d.seq_length = 3'd0;
              st_d.mode       = M_STR;
              group_o         = utf8_encode(acc_cont, st_q.seq_length);
            end
          end
        end
      end

      default: begin
        if (!end_i && b == ChQuote) begin
          st_d      = StateReset;
          st_d.mode = M_STR;
        end else begin
          st_d    = StateReset;
          group_o = error_group(ERR_NO_QUOTE);
        end
      end
    endcase
  end

  // State register, advanced once per decoded byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

### rtl/jsu_emit.sv
`default_nettype none

// Result register: holds one byte's results, sends them one a cycle when ready.
module jsu_emit
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire group_t     group_i,
  output logic            free_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output res_t            res_o,
  output logic            last_o
);

  group_t     grp_q;
  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic       fire;

  assign res_o   = grp_q.res[idx_q];
  assign last_o  = ({1'b0, idx_q} == grp_q.count - 3'd1);
  assign valid_o = valid_q;
  assign fire    = valid_q && ready_i;
  assign free_o  = !valid_q || (ready_i && last_o);

  // Step through the held group, or take a new one when it is drained.
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (fire) begin
      if (last_o) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      idx_d   = 2'd0;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= group_i;
    end
  end

endmodule

`default_nettype wire

### rtl/jsu_checker.sv
`default_nettype none

module jsu_checker
  import jsu_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A stalled output transaction stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

  // A stalled output transaction keeps its payload.
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output payload changed under stall");

  // Data results carry no error code; done and error results carry no byte.
  a_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser == KIND_DATA) ? (m_axis_tdata[10:8] == 3'd0)
                                   : (m_axis_tdata[7:0] == 8'd0))
      && (m_axis_tdata[15:11] == 5'd0))
    else $error("unused output field not zero");

  // Done and error results always end the output of their input byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_DATA) |-> m_axis_tlast)
    else $error("done or error result without tlast");

endmodule

bind json_string_unescape_utf8_check jsu_checker u_jsu_checker (.*);

`default_nettype wire

### sim/tb_json_string_unescape_utf8_check.sv
module tb_json_string_unescape_utf8_check;
  import jsu_pkg::*;

  // One input transaction: a text byte or the end-of-input marker.
  typedef struct {
    logic [7:0] b;
    logic       at_end;
  } in_item_t;

  // One decoded result as it should appear on the output stream.
  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    err_e       code;
    logic       last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        s_axis_tuser = 1'b0;    // [0] at_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [10:8] error_code
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;

  // Decoder state as predicted from the accepted bytes.
  mode_e       dec_mode = M_IDLE;
  logic [20:0] dec_acc = '0;
  logic [9:0]  dec_high = '0;
  logic [1:0]  dec_digits = '0;
  logic [1:0]  dec_left = '0;
  logic [2:0]  dec_len = '0;

  result_t  step_results[$];
  result_t  expected_results[$];
  in_item_t pending_bytes[$];

  int       items_sent = 0;
  int       strings_opened = 0;
  int       data_seen = 0;
  int       done_seen = 0;
  int       errors_seen = 0;
  int       fail_count = 0;
  logic [5:0] codes_seen = '0;
  int       burst_left = 0;
  logic     steady = 1'b0;
  int       hold_request = 0;

  json_string_unescape_utf8_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_decoder();
    dec_mode   = M_IDLE;
    dec_acc    = '0;
    dec_high   = '0;
    dec_digits = '0;
    dec_left   = '0;
    dec_len    = '0;
  endfunction

  function automatic void push_result(input kind_e k, input logic [7:0] d, input err_e c);
    result_t r;
    r.kind = k;
    r.data = d;
    r.code = c;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  // Any error drops the whole string and returns to idle.
  function automatic void raise_error(input err_e c);
    reset_decoder();
    push_result(KIND_ERROR, 8'h00, c);
  endfunction

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  // Emits a code point as UTF-8 in the given number of bytes, lead byte first.
  function automatic void emit_utf8(input logic [20:0] cp, input logic [2:0] len);
    int         shift;
    logic [7:0] mark;
    logic [7:0] mask;
    if (len <= 3'd1) begin
      push_result(KIND_DATA, 8'(cp) & 8'h7F, ERR_NO_QUOTE);
    end else begin
      case (len)
        3'd2: begin
          mark = 8'hC0; mask = 8'h1F; shift = 6;
        end
        3'd3: begin
          mark = 8'hE0; mask = 8'h0F; shift = 12;
        end
        default: begin
          mark = 8'hF0; mask = 8'h07; shift = 18;
        end
      endcase
      push_result(KIND_DATA, mark | (8'(cp >> shift) & mask), ERR_NO_QUOTE);
      for (shift = shift - 6; shift >= 0; shift = shift - 6) begin
        push_result(KIND_DATA, 8'h80 | (8'(cp >> shift) & 8'h3F), ERR_NO_QUOTE);
      end
    end
  endfunction

  function automatic void start_sequence(input logic [7:0] payload, input logic [1:0] left,
                                         input logic [2:0] len);
    dec_acc  = 21'(payload);
    dec_left = left;
    dec_len  = len;
    dec_mode = M_CONT;
  endfunction

  // Works out every result that one accepted byte causes and queues them.
  function automatic void decode_byte(input logic [7:0] b, input logic at_end);
    logic [4:0]  nib;
    logic [15:0] unit;
    logic [20:0] cp;
    logic [7:0]  esc;
    logic        bad;
    step_results = {};
    case (dec_mode)
      M_STR: begin
        if (at_end) begin
          raise_error(ERR_UNTERMINATED);
        end else if (b == ChQuote) begin
          reset_decoder();
          push_result(KIND_DONE, 8'h00, ERR_NO_QUOTE);
        end else if (b == ChBackslash) begin
          dec_mode = M_ESC;
        end else if (b < 8'h20) begin
          raise_error(ERR_CONTROL);
        end else if (b < 8'h80) begin
          push_result(KIND_DATA, b, ERR_NO_QUOTE);
        end else if (b >= 8'hC0 && b <= 8'hDF) begin
          start_sequence(b & 8'h1F, 2'd1, 3'd2);
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          start_sequence(b & 8'h0F, 2'd2, 3'd3);
        end else if (b >= 8'hF0 && b <= 8'hF7) begin
          start_sequence(b & 8'h07, 2'd3, 3'd4);
        end else begin
          raise_error(ERR_BAD_UTF8);
        end
      end
      M_ESC: begin
        if (at_end) begin
          raise_error(ERR_BAD_ESCAPE);
        end else if (b == ChLowerU) begin
          dec_mode   = M_HEX1;
          dec_acc    = '0;
          dec_digits = '0;
        end else begin
          bad = 1'b0;
          esc = b;
          case (b)
            ChQuote, ChBackslash, ChSlash: esc = b;
            ChLowerB: esc = CtlBackspace;
            ChLowerF: esc = CtlFormFeed;
            ChLowerN: esc = CtlNewline;
            ChLowerR: esc = CtlReturn;
            ChLowerT: esc = CtlTab;
            default:  bad = 1'b1;
          endcase
          if (bad) begin
            raise_error(ERR_BAD_ESCAPE);
          end else begin
            dec_mode = M_STR;
            push_result(KIND_DATA, esc, ERR_NO_QUOTE);
          end
        end
      end
      M_HEX1, M_HEX2: begin
        nib = hex_nibble(b);
        if (at_end || !nib[4]) begin
          raise_error(ERR_BAD_UNICODE);
        end else begin
          dec_acc = {dec_acc[16:0], nib[3:0]};
          if (dec_digits < 2'd3) begin
            dec_digits = dec_digits + 2'd1;
          end else begin
            dec_digits = '0;
            unit = dec_acc[15:0];
            dec_acc = '0;
            if (dec_mode == M_HEX1) begin
              if (unit < 16'hD800 || unit > 16'hDFFF) begin
                dec_mode = M_STR;
                emit_utf8(21'(unit), unit < 16'h80 ? 3'd1 : unit < 16'h800 ? 3'd2 : 3'd3);
              end else if (unit >= 16'hDC00) begin
                raise_error(ERR_BAD_UNICODE);
              end else begin
                // High half of a pair; the low half must follow as \uDCxx..\uDFxx.
                dec_high = 10'(unit - 16'hD800);
                dec_mode = M_WANT_BS;
              end
            end else if (unit < 16'hDC00 || unit > 16'hDFFF) begin
              raise_error(ERR_BAD_UNICODE);
            end else begin
              cp = 21'({dec_high, 10'd0}) + 21'(unit - 16'hDC00) + 21'h10000;
              dec_high = '0;
              dec_mode = M_STR;
              emit_utf8(cp, 3'd4);
            end
          end
        end
      end
      M_WANT_BS: begin
        if (at_end || b != ChBackslash) raise_error(ERR_BAD_UNICODE);
        else dec_mode = M_WANT_U;
      end
      M_WANT_U: begin
        if (at_end || b != ChLowerU) begin
          raise_error(ERR_BAD_UNICODE);
        end else begin
          dec_mode   = M_HEX2;
          dec_acc    = '0;
          dec_digits = '0;
        end
      end
      M_CONT: begin
        if (at_end || b[7:6] != 2'b10) begin
          raise_error(ERR_BAD_UTF8);
        end else begin
          dec_acc  = {dec_acc[14:0], b[5:0]};
          dec_left = dec_left - 2'd1;
          if (dec_left == 2'd0) begin
            cp = dec_acc;
            // Reject overlong forms, encoded surrogates and values past the last plane.
            if (dec_len == 3'd2) bad = cp < 21'h80;
            else if (dec_len == 3'd3) bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
            else bad = cp < 21'h10000 || cp > 21'h10FFFF;
            if (bad) begin
              raise_error(ERR_BAD_UTF8);
            end else begin
              esc = 8'(dec_len);
              dec_acc  = '0;
              dec_len  = '0;
              dec_mode = M_STR;
              emit_utf8(cp, esc[2:0]);
            end
          end
        end
      end
      default: begin
        if (!at_end && b == ChQuote) begin
          reset_decoder();
          dec_mode = M_STR;
          strings_opened++;
        end else begin
          raise_error(ERR_NO_QUOTE);
        end
      end
    endcase
    if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b);
    in_item_t it;
    it.b = b;
    it.at_end = 1'b0;
    pending_bytes.push_back(it);
  endfunction

  // End marker; the byte lane carries random junk that must be ignored.
  function automatic void push_end();
    in_item_t it;
    it.b = 8'($urandom);
    it.at_end = 1'b1;
    pending_bytes.push_back(it);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 8'd10);
  endfunction

  function automatic void push_u_escape(input logic [15:0] v);
    push_byte(ChBackslash);
    push_byte(ChLowerU);
    push_byte(hex_char(v[15:12]));
    push_byte(hex_char(v[11:8]));
    push_byte(hex_char(v[7:4]));
    push_byte(hex_char(v[3:0]));
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic logic [15:0] rand_high_half();
    return 16'(16'hD800 + $urandom_range(0, 10'h3FF));
  endfunction

  // A well-formed raw UTF-8 sequence of the given length with random payload.
  function automatic void queue_raw_utf8(input int len);
    logic [7:0] lead;
    if (len == 2) begin
      push_byte(8'($urandom_range(8'hC2, 8'hDF)));
    end else if (len == 3) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      push_byte(lead);
      if (lead == 8'hE0) push_byte(8'($urandom_range(8'hA0, 8'hBF)));
      else if (lead == 8'hED) push_byte(8'($urandom_range(8'h80, 8'h9F)));
      else push_byte(rand_cont());
    end else begin
      lead = 8'($urandom_range(8'hF0, 8'hF4));
      push_byte(lead);
      if (lead == 8'hF0) push_byte(8'($urandom_range(8'h90, 8'hBF)));
      else if (lead == 8'hF4) push_byte(8'($urandom_range(8'h80, 8'h8F)));
      else push_byte(rand_cont());
      push_byte(rand_cont());
    end
    push_byte(rand_cont());
  endfunction

  function automatic void queue_good_token();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0: begin
        b = 8'($urandom_range(8'h20, 8'h7F));
        if (b == ChQuote || b == ChBackslash) b = "a";
        push_byte(b);
      end
      1: begin
        push_byte(ChBackslash);
        case ($urandom_range(0, 7))
          0: push_byte(ChQuote);
          1: push_byte(ChBackslash);
          2: push_byte(ChSlash);
          3: push_byte(ChLowerB);
          4: push_byte(ChLowerF);
          5: push_byte(ChLowerN);
          6: push_byte(ChLowerR);
          default: push_byte(ChLowerT);
        endcase
      end
      2: begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(0, 16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          default: v = 16'($urandom_range(16'h800, 16'hFFFF));
        endcase
        if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h2000;
        push_u_escape(v);
      end
      3: begin
        push_u_escape(rand_high_half());
        push_u_escape(16'(16'hDC00 + $urandom_range(0, 10'h3FF)));
      end
      default: queue_raw_utf8($urandom_range(2, 4));
    endcase
  endfunction

  // A malformed tail that ends the string with an error.
  function automatic void queue_fault();
    logic [7:0]  b;
    logic [15:0] v;
    logic [4:0]  nib;
    int          n;
    case ($urandom_range(0, 12))
      0: push_byte(8'($urandom_range(0, 8'h1F)));
      1: push_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                        : 8'($urandom_range(8'hF8, 8'hFF)));
      2: begin
        push_byte(8'($urandom_range(8'hC0, 8'hC1)));
        push_byte(rand_cont());
      end
      3: begin
        if ($urandom_range(0, 1)) begin
          push_byte(8'hE0);
          push_byte(8'($urandom_range(8'h80, 8'h9F)));
        end else begin
          push_byte(8'hED);
          push_byte(8'($urandom_range(8'hA0, 8'hBF)));
        end
        push_byte(rand_cont());
      end
      4: begin
        case ($urandom_range(0, 2))
          0: begin
            push_byte(8'hF0);
            push_byte(8'($urandom_range(8'h80, 8'h8F)));
          end
          1: begin
            push_byte(8'hF4);
            push_byte(8'($urandom_range(8'h90, 8'hBF)));
          end
          default: begin
            push_byte(8'($urandom_range(8'hF5, 8'hF7)));
            push_byte(rand_cont());
          end
        endcase
        push_byte(rand_cont());
        push_byte(rand_cont());
      end
      5: begin
        // Sequence broken by a byte that is not a continuation.
        n = $urandom_range(2, 4);
        push_byte(n == 2 ? 8'hC3 : n == 3 ? 8'hE2 : 8'hF1);
        repeat ($urandom_range(0, n - 2)) push_byte(rand_cont());
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b = b ^ 8'h40;
        push_byte(b);
      end
      6: begin
        b = 8'($urandom);
        case (b)
          ChQuote, ChBackslash, ChSlash, ChLowerB, ChLowerF, ChLowerN, ChLowerR, ChLowerT,
          ChLowerU: b = "x";
          default: ;
        endcase
        push_byte(ChBackslash);
        push_byte(b);
      end
      7: begin
        // Non-hex digit in the first or the second escape of a pair.
        if ($urandom_range(0, 1)) push_u_escape(rand_high_half());
        push_byte(ChBackslash);
        push_byte(ChLowerU);
        repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
        b = 8'($urandom);
        nib = hex_nibble(b);
        if (nib[4]) b = "g";
        push_byte(b);
      end
      8: push_u_escape(16'(16'hDC00 + $urandom_range(0, 10'h3FF)));
      9: begin
        push_u_escape(rand_high_half());
        b = 8'($urandom);
        if (b == ChBackslash) b = "q";
        push_byte(b);
      end
      10: begin
        push_u_escape(rand_high_half());
        push_byte(ChBackslash);
        b = 8'($urandom);
        if (b == ChLowerU) b = "n";
        push_byte(b);
      end
      11: begin
        push_u_escape(rand_high_half());
        v = 16'($urandom);
        if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h2000;
        push_u_escape(v);
      end
      default: begin
        // Input ends part way through some construct.
        case ($urandom_range(0, 6))
          0: ;
          1: push_byte(ChBackslash);
          2: begin
            push_byte(ChBackslash);
            push_byte(ChLowerU);
            repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
          end
          3: push_u_escape(rand_high_half());
          4: begin
            push_u_escape(rand_high_half());
            push_byte(ChBackslash);
          end
          5: begin
            push_u_escape(rand_high_half());
            push_byte(ChBackslash);
            push_byte(ChLowerU);
            repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
          end
          default: begin
            n = $urandom_range(2, 4);
            push_byte(n == 2 ? 8'hC2 : n == 3 ? 8'hE1 : 8'hF1);
            repeat ($urandom_range(0, n - 2)) push_byte(rand_cont());
          end
        endcase
        push_end();
      end
    endcase
  endfunction

  function automatic void queue_random_string();
    logic [7:0] b;
    // Occasional noise while idle, before the opening quote.
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        push_end();
      end else begin
        b = 8'($urandom);
        if (b == ChQuote) b = b ^ 8'h80;
        push_byte(b);
      end
    end
    push_byte(ChQuote);
    repeat ($urandom_range(0, 5)) queue_good_token();
    if ($urandom_range(0, 3) != 0) push_byte(ChQuote);
    else queue_fault();
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: bursts with random gaps; called and returning at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b, input logic at_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= at_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, at_end);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pending();
    in_item_t it;
    while (pending_bytes.size() != 0) begin
      it = pending_bytes.pop_front();
      send_byte(it.b, it.at_end);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall patterns, plus long hold-offs on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int hold_left;
    int window;
    int pattern;
    int phase;
    hold_left = 0;
    window = 0;
    pattern = 0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (window == 0) begin
          window = $urandom_range(20, 80);
          pattern = $urandom_range(0, 2);
        end
        window--;
        case (pattern)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 99) < 60);
          default: m_axis_tready <= (phase % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("Unexpected result: kind=%0d byte=%02h code=%0d last=%0b",
                               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8],
                               m_axis_tlast));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.data ||
            m_axis_tdata[10:8] !== want.code || m_axis_tlast !== want.last) begin
          note_failure($sformatf(
              "Mismatch: exp kind=%0d byte=%02h code=%0d last=%0b got %0d/%02h/%0d/%0b",
              want.kind, want.data, want.code, want.last, m_axis_tuser,
              m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tlast));
        end else begin
          case (want.kind)
            KIND_DATA: data_seen++;
            KIND_DONE: done_seen++;
            default: begin
              errors_seen++;
              codes_seen[want.code] = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle errors, byte extremes and the longest results from both raw and escaped input.
  task automatic test_directed();
    push_byte("x");
    push_end();
    push_byte(ChQuote);
    push_byte(8'h7F);
    push_byte(8'hFF);
    push_byte(ChQuote);
    push_byte(8'h00);
    push_byte(ChQuote);
    push_byte(8'hF4);
    push_byte(8'h8F);
    push_byte(8'hBF);
    push_byte(8'hBF);
    push_u_escape(16'hDBFF);
    push_u_escape(16'hDFFF);
    push_u_escape(16'h0000);
    push_byte(ChQuote);
    push_end();
    send_pending();
  endtask

  // Mostly well-formed strings with random content, some ending in a fault.
  task automatic test_random_strings(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      queue_random_string();
      send_pending();
    end
  endtask

  // Neither side idles, so the block runs at its full rate.
  task automatic test_full_rate();
    steady = 1'b1;
    repeat (3) begin
      queue_random_string();
      send_pending();
    end
    steady = 1'b0;
  endtask

  // Output held off for a long stretch while four-byte results pile up.
  task automatic test_output_stall();
    steady = 1'b1;
    hold_request = 200;
    push_byte(ChQuote);
    repeat (3) queue_raw_utf8(4);
    push_u_escape(rand_high_half());
    push_u_escape(16'(16'hDC00 + $urandom_range(0, 10'h3FF)));
    push_byte(ChQuote);
    send_pending();
    steady = 1'b0;
  endtask

  initial begin : main
    int drain;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_strings(40);
    test_full_rate();
    test_output_stall();
    s_axis_tvalid <= 1'b0;
    drain = 0;
    while (expected_results.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", expected_results.size()));
    end
    $display("Sent %0d bytes and end markers, %0d strings opened, under bursty, steady and",
             items_sent, strings_opened);
    $display("stalled handshakes; matched %0d data, %0d done, %0d errors (codes %06b).",
             data_seen, done_seen, errors_seen, codes_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_emit.sv
rtl/json_string_unescape_utf8_check.sv
rtl/jsu_checker.sv
sim/tb_json_string_unescape_utf8_check.sv
